FILE: sv/euler_zyx_rotation_matrix_macros.svh
// Assertion macros for the euler_zyx_rotation_matrix block
`ifndef EULER_ZYX_ROTATION_MATRIX_MACROS_SVH
`define EULER_ZYX_ROTATION_MATRIX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EZR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EZR_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EZR_ASSERT(label, clk, rst, prop, msg)
`define EZR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: sv/ezr_pkg.sv
`default_nettype none
package ezr_pkg;
   localparam int CordicSteps = 14;
   localparam int AngW  = 16;
   localparam int PosW  = 24;
   localparam int ZW    = 28;   // Q.24 angle with headroom
   localparam int XW    = 32;   // Q.28 datapath
   localparam int QW    = 16;   // Q1.14 values
   localparam int StepW = $clog2(CordicSteps + 1);
   localparam int ReqW  = 3 * AngW + 3 * PosW;
   localparam int RspW  = 80;

   localparam logic signed [ZW-1:0] AngPi     = 28'sd52707179;
   localparam logic signed [ZW-1:0] AngHalfPi = 28'sd26353589;
   localparam logic signed [XW-1:0] GainQ28   = 32'sd163008219;
   localparam logic [1:0] LastRow = 2'd3;

   // One accepted word as queued between front and back
   typedef struct packed {
      logic signed [AngW-1:0] angle_x;
      logic signed [AngW-1:0] angle_y;
      logic signed [AngW-1:0] angle_z;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
   } item_type;

   // Folded angle ready for CORDIC
   typedef struct packed {
      logic signed [ZW-1:0] z;
      logic                 neg;
   } fold_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      r = '0;
      case (i)
         5'd0:  r = 28'sd13176795;
         5'd1:  r = 28'sd7778716;
         5'd2:  r = 28'sd4110060;
         5'd3:  r = 28'sd2086331;
         5'd4:  r = 28'sd1047214;
         5'd5:  r = 28'sd524117;
         5'd6:  r = 28'sd262123;
         5'd7:  r = 28'sd131069;
         5'd8:  r = 28'sd65536;
         5'd9:  r = 28'sd32768;
         5'd10: r = 28'sd16384;
         5'd11: r = 28'sd8192;
         5'd12: r = 28'sd4096;
         5'd13: r = 28'sd2048;
         5'd14: r = 28'sd1024;
         5'd15: r = 28'sd512;
         5'd16: r = 28'sd256;
         5'd17: r = 28'sd128;
         5'd18: r = 28'sd64;
         5'd19: r = 28'sd32;
         5'd20: r = 28'sd16;
         5'd21: r = 28'sd8;
         5'd22: r = 28'sd4;
         5'd23: r = 28'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [QW-1:0] sat14(input logic signed [47:0] v);
      if (v > 48'sd32767) return 16'sd32767;
      if (v < -48'sd32768) return -16'sd32768;
      return v[QW-1:0];
   endfunction
endpackage
`default_nettype wire

FILE: sv/ezr_front.sv
`default_nettype none
// Accept words, fold angles into +-pi/2, push into a two-entry queue
module ezr_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [ezr_pkg::ReqW-1:0] req_tdata,
   output logic q_valid,
   input  wire logic q_pop,
   output ezr_pkg::item_type q_item,
   output ezr_pkg::fold_type q_fx,
   output ezr_pkg::fold_type q_fy,
   output ezr_pkg::fold_type q_fz
);
   import ezr_pkg::*;

   typedef struct packed {
      item_type it;
      fold_type fx;
      fold_type fy;
      fold_type fz;
   } entry_type;

   entry_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   item_type in_item;
   entry_type in_entry;
   logic push;

   function automatic fold_type fold(input logic signed [AngW-1:0] a);
      fold_type f;
      logic signed [ZW-1:0] z;
      z = ZW'(a) <<< 11;
      f.neg = 1'b0;
      f.z = z;
      if (z > AngHalfPi) begin
         f.z = z - AngPi;
         f.neg = 1'b1;
      end else if (z < -AngHalfPi) begin
         f.z = z + AngPi;
         f.neg = 1'b1;
      end
      return f;
   endfunction

   // Unpack fields, lowest first
   always_comb begin
      in_item.angle_x = req_tdata[15:0];
      in_item.angle_y = req_tdata[31:16];
      in_item.angle_z = req_tdata[47:32];
      in_item.pos_x   = req_tdata[71:48];
      in_item.pos_y   = req_tdata[95:72];
      in_item.pos_z   = req_tdata[119:96];
      in_entry.it = in_item;
      in_entry.fx = fold(in_item.angle_x);
      in_entry.fy = fold(in_item.angle_y);
      in_entry.fz = fold(in_item.angle_z);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = mem_ff[rp_ff].it;
   assign q_fx = mem_ff[rp_ff].fx;
   assign q_fy = mem_ff[rp_ff].fy;
   assign q_fz = mem_ff[rp_ff].fz;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(q_pop && q_valid)) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop && q_valid) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_entry;
   end
endmodule
`default_nettype wire

FILE: sv/ezr_back.sv
`default_nettype none
`include "euler_zyx_rotation_matrix_macros.svh"
// Three parallel CORDIC lanes, then staged products, then four rows out
module ezr_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   output logic q_pop,
   input  wire ezr_pkg::item_type q_item,
   input  wire ezr_pkg::fold_type q_fx,
   input  wire ezr_pkg::fold_type q_fy,
   input  wire ezr_pkg::fold_type q_fz,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic rsp_tlast,
   output logic [ezr_pkg::RspW-1:0] rsp_tdata
);
   import ezr_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ROT  = 5'b00010,
      S_RND  = 5'b00100,
      S_MUL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic [StepW-1:0] step_ff;
   logic [2:0] mstep_ff;
   logic [1:0] row_ff;
   logic signed [XW-1:0] x_ff [3];
   logic signed [XW-1:0] y_ff [3];
   logic signed [ZW-1:0] z_ff [3];
   logic neg_ff [3];
   logic signed [QW-1:0] s_ff [3];
   logic signed [QW-1:0] c_ff [3];
   item_type it_ff;
   // two-factor products and matrix entries
   logic signed [31:0] p_ff [6];
   logic signed [QW-1:0] m_ff [9];
   logic signed [47:0] t_ff [4];
   logic signed [47:0] u_ff [4];
   // output register
   logic ov_ff;
   logic [RspW-1:0] od_ff;
   logic ol_ff;
   logic take;

   assign take = !ov_ff || rsp_tready;
   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tlast = ol_ff;

   function automatic logic signed [QW-1:0] rnd14(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      logic signed [QW:0] t;
      r = (v + XW'(32'sd8192)) >>> 14;
      t = r[QW:0];
      return t[QW-1:0];
   endfunction

   function automatic logic signed [QW-1:0] rnd28(input logic signed [47:0] v);
      logic signed [47:0] r;
      r = (v + 48'sd134217728) >>> 28;
      return sat14(r);
   endfunction

   function automatic logic [23:0] sx24(input logic signed [QW-1:0] v);
      return {{8{v[QW-1]}}, v};
   endfunction

   // Sequence one item through rotate, round, multiply, output
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (q_valid) st_in = S_ROT;
         S_ROT:  if (step_ff == StepW'(CordicSteps - 1)) st_in = S_RND;
         S_RND:  st_in = S_MUL;
         S_MUL:  if (mstep_ff == 3'd3) st_in = S_OUT;
         S_OUT:  if (take && row_ff == LastRow) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         step_ff <= '0;
         mstep_ff <= '0;
         row_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_ROT) step_ff <= step_ff + StepW'(1);
         else step_ff <= '0;
         if (st_ff == S_MUL) mstep_ff <= mstep_ff + 3'd1;
         else mstep_ff <= '0;
         if (st_ff == S_OUT && take) row_ff <= row_ff + 2'd1;
         if (st_ff == S_IDLE) row_ff <= '0;
         if (st_ff == S_OUT) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: begin
            it_ff <= q_item;
            for (int k = 0; k < 3; k++) begin
               x_ff[k] <= GainQ28;
               y_ff[k] <= '0;
            end
            z_ff[0] <= q_fx.z; neg_ff[0] <= q_fx.neg;
            z_ff[1] <= q_fy.z; neg_ff[1] <= q_fy.neg;
            z_ff[2] <= q_fz.z; neg_ff[2] <= q_fz.neg;
         end
         S_ROT: begin
            for (int k = 0; k < 3; k++) begin
               if (!z_ff[k][ZW-1]) begin
                  x_ff[k] <= x_ff[k] - (y_ff[k] >>> step_ff);
                  y_ff[k] <= y_ff[k] + (x_ff[k] >>> step_ff);
                  z_ff[k] <= z_ff[k] - atan_entry(5'(step_ff));
               end else begin
                  x_ff[k] <= x_ff[k] + (y_ff[k] >>> step_ff);
                  y_ff[k] <= y_ff[k] - (x_ff[k] >>> step_ff);
                  z_ff[k] <= z_ff[k] + atan_entry(5'(step_ff));
               end
            end
         end
         S_RND: begin
            for (int k = 0; k < 3; k++) begin
               if (neg_ff[k]) begin
                  s_ff[k] <= sat14(-48'(rnd14(y_ff[k])));
                  c_ff[k] <= sat14(-48'(rnd14(x_ff[k])));
               end else begin
                  s_ff[k] <= rnd14(y_ff[k]);
                  c_ff[k] <= rnd14(x_ff[k]);
               end
            end
         end
         S_MUL: begin
            case (mstep_ff)
               3'd0: begin
                  // sx*sy, cx*sy, cx*sz, cx*cz, sx*sz, sx*cz
                  p_ff[0] <= s_ff[0] * s_ff[1];
                  p_ff[1] <= c_ff[0] * s_ff[1];
                  p_ff[2] <= c_ff[0] * s_ff[2];
                  p_ff[3] <= c_ff[0] * c_ff[2];
                  p_ff[4] <= s_ff[0] * s_ff[2];
                  p_ff[5] <= s_ff[0] * c_ff[2];
                  m_ff[0] <= sat14((48'(c_ff[1] * c_ff[2]) + 48'sd8192) >>> 14);
                  m_ff[1] <= sat14((48'(c_ff[1] * s_ff[2]) + 48'sd8192) >>> 14);
                  m_ff[2] <= sat14(-48'(s_ff[1]));
                  m_ff[5] <= sat14((48'(s_ff[0] * c_ff[1]) + 48'sd8192) >>> 14);
                  m_ff[8] <= sat14((48'(c_ff[0] * c_ff[1]) + 48'sd8192) >>> 14);
               end
               3'd1: begin
                  t_ff[0] <= 48'(p_ff[0]) * 48'(c_ff[2]);
                  t_ff[1] <= 48'(p_ff[0]) * 48'(s_ff[2]);
                  t_ff[2] <= 48'(p_ff[1]) * 48'(c_ff[2]);
                  t_ff[3] <= 48'(p_ff[1]) * 48'(s_ff[2]);
                  u_ff[0] <= 48'(p_ff[2]) <<< 14;
                  u_ff[1] <= 48'(p_ff[3]) <<< 14;
                  u_ff[2] <= 48'(p_ff[4]) <<< 14;
                  u_ff[3] <= 48'(p_ff[5]) <<< 14;
               end
               3'd2: begin
                  m_ff[3] <= rnd28(t_ff[0] - u_ff[0]);
                  m_ff[4] <= rnd28(t_ff[1] + u_ff[1]);
                  m_ff[6] <= rnd28(t_ff[2] + u_ff[2]);
                  m_ff[7] <= rnd28(t_ff[3] - u_ff[3]);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Load the output register with the current row
   always_ff @(posedge clock) begin
      if (st_ff == S_OUT && take) begin
         ol_ff <= (row_ff == LastRow);
         case (row_ff)
            2'd0: od_ff <= {6'd0, sx24(m_ff[2]), sx24(m_ff[1]), sx24(m_ff[0]), row_ff};
            2'd1: od_ff <= {6'd0, sx24(m_ff[5]), sx24(m_ff[4]), sx24(m_ff[3]), row_ff};
            2'd2: od_ff <= {6'd0, sx24(m_ff[8]), sx24(m_ff[7]), sx24(m_ff[6]), row_ff};
            default: od_ff <= {6'd0, it_ff.pos_z, it_ff.pos_y, it_ff.pos_x, row_ff};
         endcase
      end
   end

   `EZR_ASSERT(a_last_row3, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[1:0] == LastRow)), "tlast disagrees with row index")
   `EZR_ASSERT(a_pop_idle, clock, reset, q_pop |-> st_ff == S_IDLE, "queue popped while busy")
   `EZR_ASSERT(a_step_rng, clock, reset, st_ff == S_ROT |-> step_ff < StepW'(CordicSteps), "cordic step overrun")
endmodule
`default_nettype wire

FILE: sv/euler_zyx_rotation_matrix.sv
`default_nettype none
// channel | dir | fields (lowest bit up)
// req     | in  | tdata: angle_x[16] angle_y[16] angle_z[16] pos_x[24] pos_y[24] pos_z[24]
// rsp     | out | tdata: row_index[2] col_first[24] col_second[24] col_third[24] pad[6]
//                 tlast: last_row
// An item runs through the iterative CORDIC loop, rounding, multiply and output states;
// the front queue holds two words so input is taken while an item is processed.
// Reset is synchronous, active high, and empties the queue and output register.
// A stalled result holds in the output register; the back end waits on it.
module euler_zyx_rotation_matrix (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [119:0] req_tdata, // angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic rsp_tlast,
   output logic [79:0] rsp_tdata // row_index, col_first, col_second, col_third
);
   import ezr_pkg::*;

   logic q_valid, q_pop;
   item_type q_item;
   fold_type q_fx, q_fy, q_fz;

   ezr_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_pop, .q_item, .q_fx, .q_fy, .q_fz
   );

   ezr_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .q_fx, .q_fy, .q_fz,
      .rsp_tvalid, .rsp_tready, .rsp_tlast, .rsp_tdata
   );
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import ezr_pkg::*;

   typedef struct {
      logic [1:0]  row;
      logic [23:0] c0;
      logic [23:0] c1;
      logic [23:0] c2;
      logic        last;
   } matrix_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [119:0] req_tdata = '0; // angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic rsp_tlast;
   logic [79:0] rsp_tdata; // row_index, col_first, col_second, col_third

   logic [119:0] pending_words[$];
   matrix_row_type expected_rows[$];
   int  fail_count = 0;
   bit  stim_done = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_cycles = 0;
   bit  hold_armed = 1'b0;
   int  accepted = 0;

   euler_zyx_rotation_matrix dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // arithmetic shift right with floor
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q(longint v, int s);
      return floor_shr(v + (longint'(1) << (s - 1)), s);
   endfunction

   function automatic longint clamp_q14(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint atan_step(int i);
      longint tab[20] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                          131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                          128, 64, 32};
      if (i < 20) return tab[i];
      if (i < 24) return longint'(1) << (24 - i);
      return 0;
   endfunction

   // CORDIC sine/cosine in Q1.14
   task automatic sin_cos(input logic signed [15:0] ang, output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(ang) * 2048;
      x = 163008219;
      y = 0;
      flip = 1'b0;
      if (z > 26353589) begin
         z -= 52707179;
         flip = 1'b1;
      end else if (z < -26353589) begin
         z += 52707179;
         flip = 1'b1;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      x = round_q(x, 14);
      y = round_q(y, 14);
      if (flip) begin
         x = -x; y = -y;
      end
      s = clamp_q14(y);
      c = clamp_q14(x);
   endtask

   function automatic longint prod2(longint a, longint b);
      return clamp_q14(round_q(a * b, 14));
   endfunction

   function automatic longint prod3(longint a, longint b, longint c, longint p, longint q,
                                    bit add);
      longint t, u;
      t = a * b * c;
      u = p * q * 16384;
      return clamp_q14(round_q(add ? t + u : t - u, 28));
   endfunction

   // compute the four rows expected for one word
   task automatic predict_matrix(input logic [119:0] w);
      longint sx, cx, sy, cy, sz, cz;
      longint m[9];
      matrix_row_type r;
      sin_cos(w[15:0], sx, cx);
      sin_cos(w[31:16], sy, cy);
      sin_cos(w[47:32], sz, cz);
      m[0] = prod2(cy, cz);
      m[1] = prod2(cy, sz);
      m[2] = clamp_q14(-sy);
      m[3] = prod3(sx, sy, cz, cx, sz, 1'b0);
      m[4] = prod3(sx, sy, sz, cx, cz, 1'b1);
      m[5] = prod2(sx, cy);
      m[6] = prod3(cx, sy, cz, sx, sz, 1'b1);
      m[7] = prod3(cx, sy, sz, sx, cz, 1'b0);
      m[8] = prod2(cx, cy);
      for (int k = 0; k < 3; k++) begin
         r.row = k[1:0];
         r.c0 = m[3*k][23:0];
         r.c1 = m[3*k+1][23:0];
         r.c2 = m[3*k+2][23:0];
         r.last = 1'b0;
         expected_rows.push_back(r);
      end
      r.row = 2'd3;
      r.c0 = w[71:48];
      r.c1 = w[95:72];
      r.c2 = w[119:96];
      r.last = 1'b1;
      expected_rows.push_back(r);
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(12868 + $urandom_range(0, 2) - 1); // near pi/2
         3: return 16'(-12868 + $urandom_range(0, 2) - 1);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // fill the stimulus queue
   initial begin
      logic [15:0] corner[8];
      corner = '{16'h0000, 16'h8000, 16'h7fff, 16'd12868, 16'd12869, -16'sd12868,
                 -16'sd12869, 16'd25736};
      for (int k = 0; k < 8; k++)
         pending_words.push_back({24'h800000, 24'h7fffff, 24'h000000,
                                  corner[(k+2)%8], corner[(k+1)%8], corner[k]});
      pending_words.push_back({24'hffffff, 24'h800000, 24'h7fffff,
                               16'hffff, 16'hffff, 16'hffff});
      pending_words.push_back({24'h000001, 24'hffffff, 24'h800000,
                               16'h8000, 16'h8000, 16'h8000});
      pending_words.push_back({24'h7fffff, 24'h000001, 24'hffffff,
                               16'h7fff, 16'h7fff, 16'h7fff});
      pending_words.push_back({24'h5a5a5a, 24'ha5a5a5, 24'h123456,
                               16'd6434, 16'd6434, 16'd6434});
      for (int k = 0; k < 210; k++)
         pending_words.push_back({24'($urandom), 24'($urandom), 24'($urandom),
                                  rand_angle(), rand_angle(), rand_angle()});
      stim_done = 1'b1;
   end

   // reset, then hand off to driver and monitor
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: present words, random gaps between them
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_matrix(req_tdata);
            accepted <= accepted + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold current word
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_tdata <= pending_words.pop_front();
            req_tvalid <= 1'b1;
            send_gap <= rand_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: compare each row with the oldest expectation
   always @(posedge clock) begin
      matrix_row_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rows.size() == 0) begin
               $display("%0t: unexpected row, expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               e = expected_rows.pop_front();
               if (rsp_tdata[1:0] !== e.row || rsp_tdata[25:2] !== e.c0 ||
                   rsp_tdata[49:26] !== e.c1 || rsp_tdata[73:50] !== e.c2 ||
                   rsp_tlast !== e.last || rsp_tdata[79:74] !== 6'd0) begin
                  $display("%0t: mismatch expected row %0d %h %h %h last %b, actual %h tlast %b",
                           $time, e.row, e.c0, e.c1, e.c2, e.last, rsp_tdata, rsp_tlast);
                  fail_count++;
               end
            end
         end
         // long stall once twenty words are accepted, else random ready
         if (!hold_armed && accepted == 20) begin
            hold_armed <= 1'b1;
            hold_cycles <= 300;
            rsp_tready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      @(posedge clock);
      wait (!reset && pending_words.size() == 0 && !req_tvalid && expected_rows.size() == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_rows.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule
